// ===== design/bankers_safety_check_core_defines.svh =====
// ---------------------------------------------------------------------------
// Banker's safety check assertion macros
// Concurrent assertion wrappers shared by the safety check RTL. They are
// compiled away in synthesis.
// ---------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_CORE_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsc assertion failed");
// Next-cycle implication, disabled during reset.
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsc assertion failed");
`else
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/bsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check package
// Sizes, codes and controller/datapath types shared by the safety check.
// ---------------------------------------------------------------------------
package bsc_pkg;

   localparam int PROCS      = 8;
   localparam int RES        = 4;
   localparam int VALUE_BITS = 8;

   localparam int PROC_BITS   = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int RES_BITS    = (RES > 1) ? $clog2(RES) : 1;
   localparam int NPROC_BITS  = $clog2(PROCS + 1);
   localparam int NRES_BITS   = $clog2(RES + 1);
   localparam int WORK_BITS   = VALUE_BITS + 3;
   localparam int MEM_DEPTH   = PROCS * RES;
   localparam int ADDR_BITS   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // Fixed field widths of the channels.
   localparam int MODE_BITS     = 2;
   localparam int PIDX_BITS     = 3;
   localparam int RIDX_BITS     = 2;
   localparam int FIELD_BITS    = 8;
   localparam int OPROC_BITS    = 3;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 4;
   localparam int APROCS_BITS   = 4;
   localparam int ARES_BITS     = 3;

   localparam logic [MODE_BITS-1:0] MODE_LOAD_ROW  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOAD_FREE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RUN       = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_PROCS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_RES   = 2'd1;

   localparam logic [APROCS_BITS-1:0] ACTIVE_PROCS_RESET = 4'd5;
   localparam logic [ARES_BITS-1:0]   ACTIVE_RES_RESET   = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_DECIDE,
      ST_RLS_RD,
      ST_RLS_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic write_row;
      logic write_free;
      logic start;
      logic rd_issue;
      logic cmp;
      logic res_next;
      logic adv_proc;
      logic record;
      logic release_alloc;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic proc_finished;
      logic last_res;
      logic last_proc;
      logic last_pass;
      logic fit;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

// ===== design/bsc_req_if.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check request channel
// Valid/ready channel carrying one load or run item per beat.
// ---------------------------------------------------------------------------
interface bsc_req_if import bsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [PIDX_BITS-1:0]  proc_index;
   logic [RIDX_BITS-1:0]  res_index;
   logic [FIELD_BITS-1:0] allocated;
   logic [FIELD_BITS-1:0] maximum_claim;
   logic [FIELD_BITS-1:0] free_units;

   modport source (
      output valid, mode, proc_index, res_index, allocated, maximum_claim, free_units,
      input  ready
   );
   modport sink (
      input  valid, mode, proc_index, res_index, allocated, maximum_claim, free_units,
      output ready
   );
endinterface

// ===== design/bsc_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check response channel
// Valid/ready channel carrying one entry of the safe sequence per beat.
// ---------------------------------------------------------------------------
interface bsc_rsp_if import bsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OPROC_BITS-1:0] order_proc;
   logic                  entry_present;
   logic                  all_safe;
   logic                  last;

   modport source (
      output valid, order_proc, entry_present, all_safe, last,
      input  ready
   );
   modport sink (
      input  valid, order_proc, entry_present, all_safe, last,
      output ready
   );
endinterface

// ===== design/bsc_csr_if.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check register write channel
// Valid/ready channel carrying a register index and write data per beat.
// ---------------------------------------------------------------------------
interface bsc_csr_if import bsc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bankers_safety_check_core.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check core
// Loads are modes 0 and 1; one item can be accepted per cycle while the controller is idle.
// Each entry that a run visits in the single-ported row memory costs a read and
// then a compare or an add.
// Synchronous active-high reset: registers 5 and 3, empty work vector, no results.
// ---------------------------------------------------------------------------
`include "bankers_safety_check_core_defines.svh"

// A run item starts a scan that the controller walks one resource of one
// process at a time: a row memory read, then a compare of the need against
// the work vector. A process whose needs all fit is recorded in the order
// buffer, and a second sweep over its row adds its allocation to the work
// vector with saturation. After active_procs passes the order buffer is
// drained through the response register, one beat per cycle while the sink
// is ready. The last beat carries the all-safe flag. When nothing could
// finish, a single beat with no entry and last set is sent.
//
// The request channel is ready only while the controller is idle and out of
// reset; the response register holds the final beat of a run, so the next
// item can be taken while that beat is still waiting. Register writes are
// taken on every cycle outside reset.
module bankers_safety_check_core import bsc_pkg::*; (
   input logic        clock,
   input logic        reset,
   bsc_req_if.sink    req_ch,
   bsc_rsp_if.source  rsp_ch,
   bsc_csr_if.sink    csr_ch
);

   cmd_type    cmd;
   status_type status;

   // Register writes are to be issued only while the block is idle; the block does
   // not enforce it. The write channel never pushes back once reset is released.
   assign csr_ch.ready = !reset;

   bsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_proc_index    (req_ch.proc_index),
      .req_res_index     (req_ch.res_index),
      .req_allocated     (req_ch.allocated),
      .req_maximum_claim (req_ch.maximum_claim),
      .req_free_units    (req_ch.free_units),
      .csr_we            (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_order_proc    (rsp_ch.order_proc),
      .rsp_entry_present (rsp_ch.entry_present),
      .rsp_all_safe      (rsp_ch.all_safe),
      .rsp_last          (rsp_ch.last)
   );

   // A run beat keeps the request side closed on the following cycle.
   `BSC_ASSERT_NEXT(a_run_blocks_req, clock, reset, req_ch.valid && req_ch.ready && (req_ch.mode == MODE_RUN), !req_ch.ready)
   // An all-safe report only ever rides on the final beat of a run.
   `BSC_ASSERT_IMPL(a_safe_on_last, clock, reset, rsp_ch.valid && rsp_ch.all_safe, rsp_ch.last && rsp_ch.entry_present)
   // A beat without an entry is the lone, unsafe report of a run.
   `BSC_ASSERT_IMPL(a_empty_is_last, clock, reset, rsp_ch.valid && !rsp_ch.entry_present, rsp_ch.last && !rsp_ch.all_safe)

endmodule

// ===== design/bsc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check controller
// Sequences loads, the pass/process/resource scan and the result drain.
// ---------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [MODE_BITS-1:0] req_mode,
   output logic                 req_ready,
   input  status_type           status,
   output cmd_type              cmd
);

   state_type state_ff;
   state_type state_in;
   logic      scan_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The scan ends when the last process of the last pass has been handled.
   assign scan_done = status.last_proc && status.last_pass;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Nothing is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               case (req_mode)
                  MODE_LOAD_ROW:  cmd.write_row  = 1'b1;
                  MODE_LOAD_FREE: cmd.write_free = 1'b1;
                  MODE_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.proc_finished) begin
               cmd.adv_proc = 1'b1;
               state_in     = scan_done ? ST_EMIT : ST_SCAN;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp      = 1'b1;
            cmd.res_next = 1'b1;
            state_in     = status.last_res ? ST_DECIDE : ST_SCAN;
         end
         ST_DECIDE: begin
            if (status.fit) begin
               cmd.record = 1'b1;
               state_in   = ST_RLS_RD;
            end else begin
               cmd.adv_proc = 1'b1;
               state_in     = scan_done ? ST_EMIT : ST_SCAN;
            end
         end
         ST_RLS_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RLS_ADD;
         end
         ST_RLS_ADD: begin
            cmd.release_alloc = 1'b1;
            cmd.res_next      = 1'b1;
            if (status.last_res) begin
               cmd.adv_proc = 1'b1;
               state_in     = scan_done ? ST_EMIT : ST_SCAN;
            end else begin
               state_in = ST_RLS_RD;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/bsc_datapath.sv =====
// ---------------------------------------------------------------------------
// Banker's safety check datapath
// Holds the tables, work vector, scan counters, order buffer and the
// response register; acts on controller commands.
// ---------------------------------------------------------------------------
module bsc_datapath import bsc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [PIDX_BITS-1:0]     req_proc_index,
   input  logic [RIDX_BITS-1:0]     req_res_index,
   input  logic [FIELD_BITS-1:0]    req_allocated,
   input  logic [FIELD_BITS-1:0]    req_maximum_claim,
   input  logic [FIELD_BITS-1:0]    req_free_units,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [OPROC_BITS-1:0]    rsp_order_proc,
   output logic                     rsp_entry_present,
   output logic                     rsp_all_safe,
   output logic                     rsp_last
);

   // Configuration registers.
   logic [APROCS_BITS-1:0] active_procs_ff;
   logic [ARES_BITS-1:0]   active_res_ff;
   logic [NPROC_BITS-1:0]  nproc;
   logic [NRES_BITS-1:0]   nres;

   // Allocation and maximum claim share one row memory, {alloc, max}.
   logic [2*VALUE_BITS-1:0] row_mem_ff [MEM_DEPTH];
   logic [2*VALUE_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic                    row_in_range;

   logic [VALUE_BITS-1:0] free_ff [RES];
   logic [WORK_BITS-1:0]  work_ff [RES];
   logic [PROCS-1:0]      finished_ff;
   logic [PROC_BITS-1:0]  order_ff [PROCS];

   logic [PROC_BITS-1:0]  proc_ff;
   logic [PROC_BITS-1:0]  pass_ff;
   logic [RES_BITS-1:0]   res_ff;
   logic                  fit_ff;
   logic [NPROC_BITS-1:0] count_ff;
   logic [PROC_BITS-1:0]  oidx_ff;

   logic [VALUE_BITS-1:0] rd_alloc;
   logic [VALUE_BITS-1:0] rd_max;
   logic [VALUE_BITS-1:0] need;
   logic                  need_fits;
   logic [WORK_BITS:0]    work_sum;
   logic [WORK_BITS-1:0]  work_sat;

   logic                  rsp_valid_ff;
   logic [OPROC_BITS-1:0] rsp_proc_ff;
   logic                  rsp_present_ff;
   logic                  rsp_safe_ff;
   logic                  rsp_last_ff;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_procs_ff <= ACTIVE_PROCS_RESET;
         active_res_ff   <= ACTIVE_RES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_PROCS: active_procs_ff <= csr_data[APROCS_BITS-1:0];
            CSR_ACTIVE_RES:   active_res_ff   <= csr_data[ARES_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the active counts to 1..PROCS and 1..RES.
   always_comb begin
      if (active_procs_ff == '0) begin
         nproc = NPROC_BITS'(1);
      end else if (int'(active_procs_ff) > PROCS) begin
         nproc = NPROC_BITS'(PROCS);
      end else begin
         nproc = NPROC_BITS'(active_procs_ff);
      end
      if (active_res_ff == '0) begin
         nres = NRES_BITS'(1);
      end else if (int'(active_res_ff) > RES) begin
         nres = NRES_BITS'(RES);
      end else begin
         nres = NRES_BITS'(active_res_ff);
      end
   end

   assign row_in_range = (int'(req_proc_index) < PROCS) && (int'(req_res_index) < RES);
   assign wr_addr = ADDR_BITS'(req_proc_index) * ADDR_BITS'(RES) + ADDR_BITS'(req_res_index);
   assign rd_addr = ADDR_BITS'(proc_ff) * ADDR_BITS'(RES) + ADDR_BITS'(res_ff);

   always_ff @(posedge clock) begin
      if (cmd.write_row && row_in_range) begin
         row_mem_ff[wr_addr] <= {req_allocated[VALUE_BITS-1:0],
                                 req_maximum_claim[VALUE_BITS-1:0]};
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_free && (int'(req_res_index) < RES)) begin
         free_ff[RES_BITS'(req_res_index)] <= req_free_units[VALUE_BITS-1:0];
      end
   end

   assign rd_alloc  = rd_data_ff[2*VALUE_BITS-1:VALUE_BITS];
   assign rd_max    = rd_data_ff[VALUE_BITS-1:0];
   assign need      = (rd_max > rd_alloc) ? (rd_max - rd_alloc) : '0;
   assign need_fits = WORK_BITS'(need) <= work_ff[res_ff];
   assign work_sum  = {1'b0, work_ff[res_ff]} + (WORK_BITS+1)'(rd_alloc);
   assign work_sat  = work_sum[WORK_BITS] ? '1 : work_sum[WORK_BITS-1:0];

   // Work vector: loaded from the free counts at start, grown on release.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RES; i++) begin
            work_ff[i] <= '0;
         end
      end else if (cmd.start) begin
         for (int i = 0; i < RES; i++) begin
            work_ff[i] <= (i < int'(nres)) ? WORK_BITS'(free_ff[i]) : '0;
         end
      end else if (cmd.release_alloc) begin
         work_ff[res_ff] <= work_sat;
      end
   end

   // Scan counters and the per-process fit flag. Moving to the next process
   // restarts the resource counter, so it takes precedence over a resource step.
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_ff     <= '0;
         pass_ff     <= '0;
         res_ff      <= '0;
         fit_ff      <= 1'b1;
         finished_ff <= '0;
         count_ff    <= '0;
      end else if (cmd.start) begin
         proc_ff     <= '0;
         pass_ff     <= '0;
         res_ff      <= '0;
         fit_ff      <= 1'b1;
         finished_ff <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.cmp) begin
            fit_ff <= fit_ff & need_fits;
         end
         if (cmd.record) begin
            finished_ff[proc_ff] <= 1'b1;
            count_ff             <= count_ff + NPROC_BITS'(1);
         end
         if (cmd.adv_proc) begin
            res_ff <= '0;
            fit_ff <= 1'b1;
            if (status.last_proc) begin
               proc_ff <= '0;
               pass_ff <= pass_ff + PROC_BITS'(1);
            end else begin
               proc_ff <= proc_ff + PROC_BITS'(1);
            end
         end else if (cmd.res_next) begin
            res_ff <= status.last_res ? '0 : res_ff + RES_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.record) begin
         order_ff[count_ff[PROC_BITS-1:0]] <= proc_ff;
      end
   end

   // Response register, decoupled from the scan by its own valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         oidx_ff      <= '0;
      end else begin
         if (cmd.start) begin
            oidx_ff <= '0;
         end else if (cmd.load_rsp) begin
            oidx_ff <= oidx_ff + PROC_BITS'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_proc_ff    <= (count_ff == '0) ? '0 : OPROC_BITS'(order_ff[oidx_ff]);
         rsp_present_ff <= count_ff != '0;
         rsp_last_ff    <= status.emit_last;
         rsp_safe_ff    <= status.emit_last && (count_ff == nproc);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_order_proc    = rsp_proc_ff;
   assign rsp_entry_present = rsp_present_ff;
   assign rsp_all_safe      = rsp_safe_ff;
   assign rsp_last          = rsp_last_ff;

   assign status.proc_finished = finished_ff[proc_ff];
   assign status.last_res      = (NRES_BITS'(res_ff) + NRES_BITS'(1)) == nres;
   assign status.last_proc     = (NPROC_BITS'(proc_ff) + NPROC_BITS'(1)) == nproc;
   assign status.last_pass     = (NPROC_BITS'(pass_ff) + NPROC_BITS'(1)) == nproc;
   assign status.fit           = fit_ff;
   assign status.out_free      = !rsp_valid_ff || rsp_ready;
   assign status.emit_last     = (count_ff == '0) ||
                                 ((NPROC_BITS'(oidx_ff) + NPROC_BITS'(1)) == count_ff);

endmodule

// ===== bench/tb_bankers_safety_check_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Banker's safety check core testbench
// Fills the allocation, claim and free tables through the request channel and
// starts safety checks under a range of process and resource counts. A
// scoreboard keeps its own copy of the tables, works out the safe order of
// every run and compares each response beat field by field. Both channels
// idle at random, and once the response side holds off long enough to back
// up the request channel.
// ---------------------------------------------------------------------------
module tb_bankers_safety_check_core;
   import bsc_pkg::*;

   // Codes that the package leaves unnamed: the unused request mode and the
   // two register indexes that decode to nothing.
   localparam logic [MODE_BITS-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [WORK_BITS-1:0] WORK_CEILING = '1;

   localparam int RANDOM_ITEMS  = 125;
   localparam int QUIET_ITEMS   = 30;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 50;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [PIDX_BITS-1:0]  proc_index;
      logic [RIDX_BITS-1:0]  res_index;
      logic [FIELD_BITS-1:0] allocated;
      logic [FIELD_BITS-1:0] maximum_claim;
      logic [FIELD_BITS-1:0] free_units;
   } req_beat_type;

   typedef struct packed {
      logic [OPROC_BITS-1:0] order_proc;
      logic                  entry_present;
      logic                  all_safe;
      logic                  last;
   } order_beat_type;

   // Keeps a private copy of the tables and registers, predicts the safe
   // order of each run as its request beat is accepted, and checks the
   // response beats against the oldest prediction.
   class safe_order_scoreboard;
      logic [APROCS_BITS-1:0] procs_reg;
      logic [ARES_BITS-1:0]   res_reg;
      logic [FIELD_BITS-1:0]  alloc_tbl [PROCS][RES];
      logic [FIELD_BITS-1:0]  claim_tbl [PROCS][RES];
      logic [FIELD_BITS-1:0]  free_tbl  [RES];
      order_beat_type         expected_order [$];
      int                     errors;
      int                     beats_checked;
      int                     safe_runs;
      int                     partial_runs;
      int                     stuck_runs;

      function new();
         procs_reg     = ACTIVE_PROCS_RESET;
         res_reg       = ACTIVE_RES_RESET;
         errors        = 0;
         beats_checked = 0;
         safe_runs     = 0;
         partial_runs  = 0;
         stuck_runs    = 0;
      endfunction

      static function int clamp_count(int value, int hi);
         return (value < 1) ? 1 : ((value > hi) ? hi : value);
      endfunction

      function int pending();
         return expected_order.size();
      endfunction

      function void accept_register(logic [CSR_IDX_BITS-1:0] idx,
                                    logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_ACTIVE_PROCS)
            procs_reg = data;
         else if (idx == CSR_ACTIVE_RES)
            res_reg = data[ARES_BITS-1:0];
      endfunction

      function void predict_safe_order();
         logic [WORK_BITS-1:0]  work [RES];
         logic [WORK_BITS:0]    sum;
         logic [FIELD_BITS-1:0] need;
         logic [PROCS-1:0]      done;
         logic [OPROC_BITS-1:0] order_list [PROCS];
         int                    nproc;
         int                    nres;
         int                    count;
         bit                    fits;
         order_beat_type        beat;

         nproc = clamp_count(int'(procs_reg), PROCS);
         nres  = clamp_count(int'(res_reg), RES);
         for (int r = 0; r < RES; r++) begin
            work[r] = '0;
            if (r < nres)
               work[r] = WORK_BITS'(free_tbl[r]);
         end
         done  = '0;
         count = 0;
         for (int pass = 0; pass < nproc; pass++) begin
            for (int p = 0; p < nproc; p++) begin
               if (!done[p]) begin
                  fits = 1'b1;
                  for (int r = 0; r < nres; r++) begin
                     need = (claim_tbl[p][r] > alloc_tbl[p][r]) ?
                            claim_tbl[p][r] - alloc_tbl[p][r] : '0;
                     if (need > work[r])
                        fits = 1'b0;
                  end
                  if (fits) begin
                     order_list[count] = OPROC_BITS'(p);
                     count++;
                     for (int r = 0; r < nres; r++) begin
                        sum     = (WORK_BITS+1)'(work[r]) + (WORK_BITS+1)'(alloc_tbl[p][r]);
                        work[r] = (sum > WORK_CEILING) ? WORK_CEILING : sum[WORK_BITS-1:0];
                     end
                     done[p] = 1'b1;
                  end
               end
            end
         end

         if (count == 0) begin
            beat.order_proc    = '0;
            beat.entry_present = 1'b0;
            beat.all_safe      = 1'b0;
            beat.last          = 1'b1;
            expected_order.push_back(beat);
            stuck_runs++;
         end else begin
            for (int i = 0; i < count; i++) begin
               beat.order_proc    = order_list[i];
               beat.entry_present = 1'b1;
               beat.last          = (i == count - 1);
               beat.all_safe      = beat.last && (count == nproc);
               expected_order.push_back(beat);
            end
            if (count == nproc)
               safe_runs++;
            else
               partial_runs++;
         end
      endfunction

      function void accept_request(req_beat_type b);
         case (b.mode)
            MODE_LOAD_ROW: begin
               alloc_tbl[b.proc_index][b.res_index] = b.allocated;
               claim_tbl[b.proc_index][b.res_index] = b.maximum_claim;
            end
            MODE_LOAD_FREE: free_tbl[b.res_index] = b.free_units;
            MODE_RUN:       predict_safe_order();
            default:        ;
         endcase
      endfunction

      function void check_beat(order_beat_type got);
         order_beat_type want;

         if (expected_order.size() == 0) begin
            $error("response beat with no run awaiting it: order_proc %0d, last %0b",
                   got.order_proc, got.last);
            errors++;
            return;
         end
         want = expected_order.pop_front();
         beats_checked++;
         if (got.order_proc !== want.order_proc) begin
            $error("order_proc mismatch: expected %0d, actual %0d",
                   want.order_proc, got.order_proc);
            errors++;
         end
         if (got.entry_present !== want.entry_present) begin
            $error("entry_present mismatch: expected %0b, actual %0b",
                   want.entry_present, got.entry_present);
            errors++;
         end
         if (got.all_safe !== want.all_safe) begin
            $error("all_safe mismatch: expected %0b, actual %0b", want.all_safe, got.all_safe);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
      endfunction

      function void close_out();
         if (expected_order.size() != 0) begin
            $error("%0d expected response beats never arrived", expected_order.size());
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bsc_req_if req_ch ();
   bsc_rsp_if rsp_ch ();
   bsc_csr_if csr_ch ();

   bankers_safety_check_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   safe_order_scoreboard board = new();

   // Stimulus bookkeeping. A run must never read a table entry that was never
   // loaded, so every load that is accepted marks its entry here.
   bit row_seen  [PROCS][RES];
   bit free_seen [RES];
   int eff_procs      = ACTIVE_PROCS_RESET;
   int eff_res        = ACTIVE_RES_RESET;
   int items_sent     = 0;
   int settings_count = 0;
   int cycle_count    = 0;
   bit quiet_tail     = 1'b0;
   bit hold_done      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side. Ready changes only at the rising edge, in random stall
   // bursts. Once, when results are waiting and the request side is blocked
   // with a beat on offer, ready is held low for a long stretch so that the
   // order buffer stays full and the request channel stalls behind it.
   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;

      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && !quiet_tail && board.beats_checked >= 10 &&
             rsp_ch.valid === 1'b1 && req_ch.valid === 1'b1 && req_ch.ready === 1'b0) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Inputs only move at the rising edge, so both handshakes are sampled at
   // the falling edge: a beat seen there is the one taken at the next rise.
   always @(negedge clock) begin : rsp_monitor
      order_beat_type got;

      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.order_proc    = rsp_ch.order_proc;
         got.entry_present = rsp_ch.entry_present;
         got.all_safe      = rsp_ch.all_safe;
         got.last          = rsp_ch.last;
         board.check_beat(got);
      end
   end

   // Every request beat carries random values in the fields its mode does not
   // use, so that all bits of every field get exercised.
   function automatic req_beat_type noise_beat(logic [MODE_BITS-1:0] mode);
      req_beat_type b;

      b.mode          = mode;
      b.proc_index    = PIDX_BITS'($urandom_range(0, 7));
      b.res_index     = RIDX_BITS'($urandom_range(0, 3));
      b.allocated     = FIELD_BITS'($urandom_range(0, 255));
      b.maximum_claim = FIELD_BITS'($urandom_range(0, 255));
      b.free_units    = FIELD_BITS'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic req_beat_type row_beat(int p, int r, int alloc, int claim);
      req_beat_type b;

      b               = noise_beat(MODE_LOAD_ROW);
      b.proc_index    = PIDX_BITS'(p);
      b.res_index     = RIDX_BITS'(r);
      b.allocated     = FIELD_BITS'(alloc);
      b.maximum_claim = FIELD_BITS'(claim);
      return b;
   endfunction

   function automatic req_beat_type free_beat(int r, int units);
      req_beat_type b;

      b            = noise_beat(MODE_LOAD_FREE);
      b.res_index  = RIDX_BITS'(r);
      b.free_units = FIELD_BITS'(units);
      return b;
   endfunction

   // Random row contents lean toward small needs so that most runs get deep
   // into their passes, with enough large needs left to block processes.
   function automatic req_beat_type random_row(int p, int r);
      int alloc;
      int claim;

      alloc = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
         0: claim = alloc + $urandom_range(0, 24);
         1: claim = $urandom_range(0, alloc);
         2: claim = $urandom_range(0, 255);
         default: begin
            alloc = $urandom_range(0, 1) ? 255 : 0;
            claim = $urandom_range(0, 1) ? 255 : 0;
         end
      endcase
      if (claim > 255)
         claim = 255;
      return row_beat(p, r, alloc, claim);
   endfunction

   function automatic req_beat_type random_free(int r);
      int units;

      case ($urandom_range(0, 3))
         0:       units = $urandom_range(0, 40);
         1:       units = $urandom_range(0, 255);
         2:       units = 255;
         default: units = 0;
      endcase
      return free_beat(r, units);
   endfunction

   // Offers one request beat, at times with a random idle burst ahead of it, and
   // returns at the rising edge that takes it.
   task automatic send_item(input req_beat_type b);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= b.mode;
      req_ch.proc_index    <= b.proc_index;
      req_ch.res_index     <= b.res_index;
      req_ch.allocated     <= b.allocated;
      req_ch.maximum_claim <= b.maximum_claim;
      req_ch.free_units    <= b.free_units;
      do @(negedge clock); while (req_ch.ready !== 1'b1);
      board.accept_request(b);
      if (b.mode == MODE_LOAD_ROW)
         row_seen[b.proc_index][b.res_index] = 1'b1;
      if (b.mode == MODE_LOAD_FREE)
         free_seen[b.res_index] = 1'b1;
      if (b.mode != MODE_UNUSED)
         items_sent++;
      @(posedge clock);
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(negedge clock); while (csr_ch.ready !== 1'b1);
      board.accept_register(idx, data);
      @(posedge clock);
   endtask

   // Registers change only with the core idle: every predicted beat has come
   // back, and a settling wait covers a load still being written.
   task automatic wait_settled();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_BITS-1:0] procs_data,
                             input logic [CSR_DATA_BITS-1:0] res_data);
      wait_settled();
      write_reg(CSR_ACTIVE_PROCS, procs_data);
      write_reg(CSR_ACTIVE_RES, res_data);
      csr_ch.valid <= 1'b0;
      eff_procs = safe_order_scoreboard::clamp_count(int'(procs_data), PROCS);
      eff_res   = safe_order_scoreboard::clamp_count(int'(res_data[ARES_BITS-1:0]), RES);
      settings_count++;
   endtask

   // Loads every entry that the next run will read and that is still empty.
   task automatic fill_needed();
      for (int p = 0; p < eff_procs; p++)
         for (int r = 0; r < eff_res; r++)
            if (!row_seen[p][r])
               send_item(random_row(p, r));
      for (int r = 0; r < eff_res; r++)
         if (!free_seen[r])
            send_item(random_free(r));
   endtask

   initial begin : stimulus
      int                       directed_count;
      int                       nloads;
      logic [CSR_DATA_BITS-1:0] procs_data;
      logic [CSR_DATA_BITS-1:0] res_data;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.mode          <= MODE_LOAD_ROW;
      req_ch.proc_index    <= '0;
      req_ch.res_index     <= '0;
      req_ch.allocated     <= '0;
      req_ch.maximum_claim <= '0;
      req_ch.free_units    <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= CSR_ACTIVE_PROCS;
      csr_ch.data          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // One process, one resource: a claim of 255 against 255 free units
      // just fits, and against 254 nothing can finish.
      set_config(4'd1, 4'd1);
      send_item(row_beat(0, 0, 0, 255));
      send_item(free_beat(0, 255));
      send_item(noise_beat(MODE_RUN));
      send_item(free_beat(0, 254));
      send_item(noise_beat(MODE_RUN));

      // All eight processes hold 255 units and need none, so the work entry
      // climbs past its ceiling and saturates.
      set_config(4'd8, 4'd1);
      for (int p = 0; p < PROCS; p++)
         send_item(row_beat(p, 0, 255, 0));
      send_item(free_beat(0, 255));
      send_item(noise_beat(MODE_RUN));

      // Unsafe state: the first two processes finish but free nothing, the
      // third needs 255 units that never appear.
      set_config(4'd3, 4'd1);
      send_item(row_beat(0, 0, 0, 0));
      send_item(row_beat(1, 0, 0, 0));
      send_item(row_beat(2, 0, 0, 255));
      send_item(free_beat(0, 0));
      send_item(noise_beat(MODE_RUN));

      // The unused mode must change nothing.
      send_item(noise_beat(MODE_UNUSED));

      // Zero counts clamp up to one.
      set_config(4'd0, 4'd0);
      send_item(noise_beat(MODE_RUN));

      // Writes to the undecoded indexes are dropped. Fifteen processes clamp
      // to eight, and a resource count of eight keeps only its low bits,
      // which clamp up to one. The blocked third process finishes only in
      // the second pass, after the later ones have released their units.
      wait_settled();
      write_reg(CSR_SPARE_2, 4'd7);
      write_reg(CSR_SPARE_3, 4'd2);
      csr_ch.valid <= 1'b0;
      set_config(4'd15, 4'd8);
      send_item(noise_beat(MODE_RUN));
      directed_count = items_sent;

      // Random part: mostly well-formed load-then-run sequences, with
      // repeated runs, stray unused-mode beats and register changes mixed in.
      while (items_sent < directed_count + RANDOM_ITEMS) begin
         quiet_tail = (items_sent >= directed_count + RANDOM_ITEMS - QUIET_ITEMS);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0:       procs_data = 4'd1;
               1:       procs_data = 4'd8;
               2:       procs_data = $urandom_range(0, 1) ? 4'd0
                                     : CSR_DATA_BITS'($urandom_range(9, 15));
               default: procs_data = CSR_DATA_BITS'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 5))
               0:       res_data = 4'd1;
               1:       res_data = 4'd4;
               2:       res_data = CSR_DATA_BITS'($urandom_range(0, 15));
               default: res_data = CSR_DATA_BITS'($urandom_range(1, 4));
            endcase
            set_config(procs_data, res_data);
         end
         nloads = $urandom_range(0, 6);
         repeat (nloads) begin
            case ($urandom_range(0, 9))
               0:       send_item(noise_beat(MODE_UNUSED));
               1, 2:    send_item(random_free($urandom_range(0, RES - 1)));
               default: send_item(random_row($urandom_range(0, PROCS - 1),
                                             $urandom_range(0, RES - 1)));
            endcase
         end
         fill_needed();
         send_item(noise_beat(MODE_RUN));
      end

      req_ch.valid <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && board.pending() != 0; i++)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      board.close_out();

      $display("Checked %0d response beats from %0d runs: %0d fully safe, %0d partly safe,",
               board.beats_checked, board.safe_runs + board.partial_runs + board.stuck_runs,
               board.safe_runs, board.partial_runs);
      $display("%0d with no process able to finish; %0d load and run beats, %0d settings.",
               board.stuck_runs, items_sent, settings_count);
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/bsc_pkg.sv
design/bsc_req_if.sv
design/bsc_rsp_if.sv
design/bsc_csr_if.sv
design/bsc_ctrl.sv
design/bsc_datapath.sv
design/bankers_safety_check_core.sv
bench/tb_bankers_safety_check_core.sv
